// ===== rtl/core/spq_pkg.sv =====
// Shared widths, codes and control types for the sorted priority queue.
`timescale 1ns / 1ps

package spq_pkg;

    localparam int ACTION_W   = 2;
    localparam int VALUE_W    = 32;
    localparam int PRIO_W     = 16;
    localparam int STATUS_W   = 2;
    localparam int OCC_W      = 5;
    localparam int CAPACITY_D = 16;

    localparam logic [ACTION_W-1:0] ACT_ENQUEUE = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_DEQUEUE = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_PEEK    = 2'd2;

    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

    localparam logic signed [VALUE_W-1:0] NO_VALUE = -32'sd1;
    localparam logic signed [VALUE_W-1:0] ENQ_VALUE = 32'sd0;

    // controller -> datapath commands
    typedef struct packed {
        logic load;   // capture request beat
        logic exec;   // apply request, load result register
    } spq_cmd_t;

endpackage

// ===== rtl/core/spq_ctrl.sv =====
// Controller: request sequencing and result handshake.
`timescale 1ns / 1ps

module spq_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    output logic              m_valid,
    input  logic              m_ready,
    output spq_pkg::spq_cmd_t cmd
);

    typedef enum logic [0:0] {
        S_IDLE,
        S_EXEC
    } state_t;

    state_t state_reg, state_next;
    logic   m_valid_reg, m_valid_next;

    assign s_ready  = (state_reg == S_IDLE);
    assign m_valid  = m_valid_reg;
    assign cmd.load = s_valid && (state_reg == S_IDLE);
    assign cmd.exec = (state_reg == S_EXEC) && (!m_valid_reg || m_ready);

    always_comb begin
        state_next   = state_reg;
        m_valid_next = m_valid_reg;
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end
        case (state_reg)
            S_IDLE: begin
                if (cmd.load) begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC: begin
                if (cmd.exec) begin
                    m_valid_next = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

`ifndef SYNTHESIS
    a_load_to_exec: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.load |=> (state_reg == S_EXEC))
        else $error("accepted request did not enter execute");

    a_exec_shows_result: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.exec |=> m_valid_reg)
        else $error("executed request produced no result beat");

    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && !m_ready && state_reg == S_EXEC) |=> (state_reg == S_EXEC))
        else $error("pending result overwritten");

    a_exec_only_in_exec: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.exec |-> !cmd.load)
        else $error("load and execute in the same cycle");
`endif

endmodule

// ===== rtl/core/spq_datapath.sv =====
// Datapath: sorted shift-register cell array, occupancy count, result register.
`timescale 1ns / 1ps

module spq_datapath #(
    parameter int CAPACITY = spq_pkg::CAPACITY_D
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  spq_pkg::spq_cmd_t                   cmd,
    input  logic [spq_pkg::ACTION_W-1:0]        s_action,
    input  logic signed [spq_pkg::VALUE_W-1:0]  s_item_value,
    input  logic [spq_pkg::PRIO_W-1:0]          s_item_priority,
    output logic signed [spq_pkg::VALUE_W-1:0]  m_result_value,
    output logic [spq_pkg::STATUS_W-1:0]        m_status,
    output logic [spq_pkg::OCC_W-1:0]           m_occupancy
);

    localparam int CW = $clog2(CAPACITY + 1);

    // request held for the execute cycle
    logic [spq_pkg::ACTION_W-1:0]        act_reg;
    logic signed [spq_pkg::VALUE_W-1:0]  val_reg;
    logic [spq_pkg::PRIO_W-1:0]          prio_reg;

    logic [CW-1:0] count_reg, count_next;

    logic signed [spq_pkg::VALUE_W-1:0] cell_val_reg  [CAPACITY];
    logic [spq_pkg::PRIO_W-1:0]         cell_prio_reg [CAPACITY];

    logic signed [spq_pkg::VALUE_W-1:0] res_value_reg, res_value_next;
    logic [spq_pkg::STATUS_W-1:0]       res_status_reg, res_status_next;
    logic [spq_pkg::OCC_W-1:0]          res_occ_reg;
    logic [CW+spq_pkg::OCC_W-1:0]       occ_ext;

    logic is_enq, is_deq, full, empty, do_enq, do_deq;
    logic [CAPACITY-1:0] ins;   // cell at or beyond the insertion point

    assign is_enq = (act_reg == spq_pkg::ACT_ENQUEUE);
    assign is_deq = (act_reg == spq_pkg::ACT_DEQUEUE);
    assign full   = (count_reg == CW'(CAPACITY));
    assign empty  = (count_reg == '0);
    assign do_enq = cmd.exec && is_enq && !full;
    assign do_deq = cmd.exec && is_deq && !empty;

    // sorted order makes ins a thermometer code
    for (genvar i = 0; i < CAPACITY; i++) begin : g_cmp
        assign ins[i] = (CW'(i) >= count_reg) || (cell_prio_reg[i] > prio_reg);
    end

    always_comb begin
        count_next = count_reg;
        if (do_enq) begin
            count_next = count_reg + CW'(1);
        end else if (do_deq) begin
            count_next = count_reg - CW'(1);
        end
        if (is_enq) begin
            res_value_next  = spq_pkg::ENQ_VALUE;
            res_status_next = full ? spq_pkg::ST_FULL : spq_pkg::ST_OK;
        end else if (empty) begin
            res_value_next  = spq_pkg::NO_VALUE;
            res_status_next = spq_pkg::ST_EMPTY;
        end else begin
            res_value_next  = cell_val_reg[0];
            res_status_next = spq_pkg::ST_OK;
        end
    end

    assign occ_ext = {{spq_pkg::OCC_W{1'b0}}, count_next};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
        end else begin
            count_reg <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            act_reg  <= s_action;
            val_reg  <= s_item_value;
            prio_reg <= s_item_priority;
        end
        if (cmd.exec) begin
            res_value_reg  <= res_value_next;
            res_status_reg <= res_status_next;
            res_occ_reg    <= occ_ext[spq_pkg::OCC_W-1:0];
        end
    end

    // each cell takes the new pair, its left neighbour, or its right neighbour
    for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
        always_ff @(posedge aclk) begin
            if (do_enq && ins[i]) begin
                if (i > 0 && ins[(i > 0) ? i - 1 : 0]) begin
                    cell_val_reg[i]  <= cell_val_reg[(i > 0) ? i - 1 : 0];
                    cell_prio_reg[i] <= cell_prio_reg[(i > 0) ? i - 1 : 0];
                end else begin
                    cell_val_reg[i]  <= val_reg;
                    cell_prio_reg[i] <= prio_reg;
                end
            end else if (do_deq && i < CAPACITY - 1) begin
                cell_val_reg[i]  <= cell_val_reg[(i < CAPACITY - 1) ? i + 1 : i];
                cell_prio_reg[i] <= cell_prio_reg[(i < CAPACITY - 1) ? i + 1 : i];
            end
        end
    end

    assign m_result_value = res_value_reg;
    assign m_status       = res_status_reg;
    assign m_occupancy    = res_occ_reg;

endmodule

// ===== rtl/core/sorted_priority_queue_top.sv =====
// Top level of the sorted priority queue: controller plus cell-array datapath.
`timescale 1ns / 1ps
// Bounded priority queue of CAPACITY (value, priority) pairs, kept sorted
// in a row of shift-register cells, smallest priority number at the head.
// Equal priorities leave in arrival order.
// Request channel (s_*): one beat per request; s_action selects enqueue,
// dequeue head or peek head (unused code behaves as peek).
// Result channel (m_*): exactly one beat per request, in request order,
// carrying the head value (-1 on empty, 0 on enqueue), a status code and
// the occupancy after the request.
//
// Timing: a request is captured on its accept edge and executed in the
// execute state once the result register is free, where every cell
// compares its priority against the new one in parallel and shifts in one
// step. The result is registered. A new request is taken only after the
// previous one has executed, set by the capture/execute sequence of the controller.
//
// While a result waits, the next request is still taken; its execute step
// holds until the result register is free, so a stalled receiver backs up
// into s_ready after one further request.
// Reset (aresetn low, synchronous) empties the queue and drops any pending
// result; the cell contents are left as they were and never read.

module sorted_priority_queue_top #(
    parameter int CAPACITY = spq_pkg::CAPACITY_D
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic [spq_pkg::ACTION_W-1:0]        s_action,
    input  logic signed [spq_pkg::VALUE_W-1:0]  s_item_value,
    input  logic [spq_pkg::PRIO_W-1:0]          s_item_priority,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic signed [spq_pkg::VALUE_W-1:0]  m_result_value,
    output logic [spq_pkg::STATUS_W-1:0]        m_status,
    output logic [spq_pkg::OCC_W-1:0]           m_occupancy
);

    spq_pkg::spq_cmd_t cmd;

    spq_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .cmd     (cmd)
    );

    spq_datapath #(
        .CAPACITY (CAPACITY)
    ) u_datapath (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cmd             (cmd),
        .s_action        (s_action),
        .s_item_value    (s_item_value),
        .s_item_priority (s_item_priority),
        .m_result_value  (m_result_value),
        .m_status        (m_status),
        .m_occupancy     (m_occupancy)
    );

endmodule

// ===== verif/spq_reply_checker.sv =====
// Reply checker for the sorted priority queue: shadow queue, expected-reply store and compare.
`timescale 1ns / 1ps

module spq_reply_checker
    import spq_pkg::*;
#(
    parameter int CAPACITY = CAPACITY_D
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       s_valid,
    input  logic                       s_ready,
    input  logic [ACTION_W-1:0]        s_action,
    input  logic signed [VALUE_W-1:0]  s_item_value,
    input  logic [PRIO_W-1:0]          s_item_priority,
    input  logic                       m_valid,
    input  logic                       m_ready,
    input  logic signed [VALUE_W-1:0]  m_result_value,
    input  logic [STATUS_W-1:0]        m_status,
    input  logic [OCC_W-1:0]           m_occupancy,
    output int                         mismatches,
    output int                         pending_replies,
    output int                         replies_checked,
    output int                         full_drops,
    output int                         empty_replies,
    output int                         peak_fill
);

    typedef struct packed {
        logic signed [VALUE_W-1:0] value;
        logic [STATUS_W-1:0]       status;
        logic [OCC_W-1:0]          occupancy;
    } spq_reply_t;

    // shadow of the sorted store, head at index 0
    logic signed [VALUE_W-1:0] held_value [CAPACITY];
    logic [PRIO_W-1:0]         held_prio  [CAPACITY];
    int                        held_count;

    spq_reply_t replies_due [$];
    spq_reply_t want;
    spq_reply_t got;
    int         bad_count;
    int         checked_count;
    int         full_count;
    int         empty_count;
    int         peak_count;

    function automatic spq_reply_t serve_request(input logic [ACTION_W-1:0]       act,
                                                 input logic signed [VALUE_W-1:0] value,
                                                 input logic [PRIO_W-1:0]         prio);
        spq_reply_t reply;
        int         slot;
        reply.value  = ENQ_VALUE;
        reply.status = ST_OK;
        if (act == ACT_ENQUEUE) begin
            if (held_count >= CAPACITY) begin
                reply.status = ST_FULL;
            end else begin
                // land behind every entry of equal or smaller priority
                slot = 0;
                while (slot < held_count && held_prio[slot] <= prio)
                    slot++;
                for (int i = held_count; i > slot; i--) begin
                    held_value[i] = held_value[i-1];
                    held_prio[i]  = held_prio[i-1];
                end
                held_value[slot] = value;
                held_prio[slot]  = prio;
                held_count++;
            end
        end else if (held_count == 0) begin
            reply.value  = NO_VALUE;
            reply.status = ST_EMPTY;
        end else begin
            reply.value = held_value[0];
            // anything but dequeue (spare code included) leaves the store alone
            if (act == ACT_DEQUEUE) begin
                for (int i = 1; i < held_count; i++) begin
                    held_value[i-1] = held_value[i];
                    held_prio[i-1]  = held_prio[i];
                end
                held_count--;
            end
        end
        reply.occupancy = OCC_W'(held_count);
        return reply;
    endfunction

    task automatic flag_reply(input string what, input bit have_want);
        bad_count++;
        if (bad_count <= 10) begin
            if (have_want) begin
                $display("%0t: %s: expected value %0d status %0d occ %0d",
                         $time, what, want.value, want.status, want.occupancy);
                $display("    got value %0d status %0d occ %0d",
                         got.value, got.status, got.occupancy);
            end else begin
                $display("%0t: %s: got value %0d status %0d occ %0d",
                         $time, what, got.value, got.status, got.occupancy);
            end
        end
    endtask

    initial begin
        held_count    = 0;
        bad_count     = 0;
        checked_count = 0;
        full_count    = 0;
        empty_count   = 0;
        peak_count    = 0;
    end

    always @(posedge aclk) begin
        if (!aresetn) begin
            held_count = 0;
            replies_due.delete();
        end else begin
            // result side first, so a reply can never match a request taken on the same edge
            if (m_valid && m_ready) begin
                got.value     = m_result_value;
                got.status    = m_status;
                got.occupancy = m_occupancy;
                checked_count++;
                if (replies_due.size() == 0) begin
                    flag_reply("reply with nothing outstanding", 1'b0);
                end else begin
                    want = replies_due.pop_front();
                    if (got.value !== want.value || got.status !== want.status ||
                        got.occupancy !== want.occupancy)
                        flag_reply("reply mismatch", 1'b1);
                end
            end
            if (s_valid && s_ready) begin
                want = serve_request(s_action, s_item_value, s_item_priority);
                replies_due.push_back(want);
                if (want.status == ST_FULL)
                    full_count++;
                if (want.status == ST_EMPTY)
                    empty_count++;
                if (held_count > peak_count)
                    peak_count = held_count;
            end
        end
        mismatches      <= bad_count;
        pending_replies <= replies_due.size();
        replies_checked <= checked_count;
        full_drops      <= full_count;
        empty_replies   <= empty_count;
        peak_fill       <= peak_count;
    end

endmodule

// ===== verif/sorted_priority_queue_top_test.sv =====
// Testbench top for the sorted priority queue: clock, reset, request and reply traffic, verdict.
`timescale 1ns / 1ps

module sorted_priority_queue_top_test;
    import spq_pkg::*;

    localparam int CAPACITY = CAPACITY_D;

    // spare action code, the block must treat it as a peek
    localparam logic [ACTION_W-1:0] ACT_SPARE = 2'd3;

    // longest quiet spell in a correct run is one long receiver stall or
    // one long sender gap plus the capture and execute steps of the block;
    // the limit leaves a wide margin over that
    localparam int WATCHDOG_LIMIT  = 2000;
    // quiet spell after the last reply, to catch stray beats
    localparam int DRAIN_CYCLES    = 16;
    localparam int RANDOM_REQUESTS = 925;

    logic                       aclk;
    logic                       aresetn         = 1'b0;
    logic                       s_valid         = 1'b0;
    logic                       s_ready;
    logic [ACTION_W-1:0]        s_action        = ACT_PEEK;
    logic signed [VALUE_W-1:0]  s_item_value    = '0;
    logic [PRIO_W-1:0]          s_item_priority = '0;
    logic                       m_valid;
    logic                       m_ready         = 1'b0;
    logic signed [VALUE_W-1:0]  m_result_value;
    logic [STATUS_W-1:0]        m_status;
    logic [OCC_W-1:0]           m_occupancy;

    int mismatches;
    int pending_replies;
    int replies_checked;
    int full_drops;
    int empty_replies;
    int peak_fill;

    // request mix actually accepted, for the closing summary
    int enq_sent    = 0;
    int deq_sent    = 0;
    int peek_sent   = 0;
    int spare_sent  = 0;

    int gap_free_left   = 0;  // remaining beats of a back-to-back sender burst
    int ready_hold      = 0;  // cycles left before the receiver rolls again
    int unsigned ready_roll;
    int idle_cycles     = 0;

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    sorted_priority_queue_top #(
        .CAPACITY (CAPACITY)
    ) uut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_action        (s_action),
        .s_item_value    (s_item_value),
        .s_item_priority (s_item_priority),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_result_value  (m_result_value),
        .m_status        (m_status),
        .m_occupancy     (m_occupancy)
    );

    spq_reply_checker #(
        .CAPACITY (CAPACITY)
    ) u_checker (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_action        (s_action),
        .s_item_value    (s_item_value),
        .s_item_priority (s_item_priority),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_result_value  (m_result_value),
        .m_status        (m_status),
        .m_occupancy     (m_occupancy),
        .mismatches      (mismatches),
        .pending_replies (pending_replies),
        .replies_checked (replies_checked),
        .full_drops      (full_drops),
        .empty_replies   (empty_replies),
        .peak_fill       (peak_fill)
    );

    // Receiver back-pressure: mostly ready, short stalls often, a long
    // stall now and then, and long fully-open stretches so the block also
    // sees an unthrottled result channel.
    always @(posedge aclk) begin
        if (ready_hold > 0) begin
            ready_hold <= ready_hold - 1;
        end else begin
            ready_roll = $urandom_range(0, 99);
            if (ready_roll < 10) begin
                m_ready    <= 1'b1;
                ready_hold <= $urandom_range(30, 80);
            end else if (ready_roll < 55) begin
                m_ready    <= 1'b1;
                ready_hold <= $urandom_range(0, 12);
            end else if (ready_roll < 93) begin
                m_ready    <= 1'b0;
                ready_hold <= $urandom_range(0, 3);
            end else begin
                m_ready    <= 1'b0;
                ready_hold <= $urandom_range(10, 40);
            end
        end
    end

    // Watchdog: any beat on either channel restarts the count.
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("watchdog: %0d cycles without a beat, %0d replies outstanding",
                         idle_cycles, pending_replies);
                $display("SCOREBOARD MISMATCH");
                $finish;
            end
        end
    end

    // Present one request and hold it until the beat is taken, then
    // perhaps leave a gap. Entered and left just after a rising edge;
    // valid is only lowered when a gap follows, so back-to-back beats
    // never see a low-then-high in the same step.
    task send_request(input logic [ACTION_W-1:0]       act,
                      input logic signed [VALUE_W-1:0] value,
                      input logic [PRIO_W-1:0]         prio);
        int gap;
        int unsigned gap_roll;
        s_action        <= act;
        s_item_value    <= value;
        s_item_priority <= prio;
        s_valid         <= 1'b1;
        do @(posedge aclk); while (!s_ready);

        case (act)
            ACT_ENQUEUE: enq_sent++;
            ACT_DEQUEUE: deq_sent++;
            ACT_PEEK:    peek_sent++;
            default:     spare_sent++;
        endcase

        gap = 0;
        if (gap_free_left > 0) begin
            gap_free_left--;
        end else begin
            gap_roll = $urandom_range(0, 99);
            if (gap_roll < 8)
                gap_free_left = $urandom_range(20, 60);
            else if (gap_roll < 55)
                gap = 0;
            else if (gap_roll < 93)
                gap = $urandom_range(1, 3);
            else
                gap = $urandom_range(8, 40);
        end
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
    endtask

    // Directed opening: empty-queue reads, field extremes, a full fill with
    // ties, a drop on full, the spare code on a loaded queue, and head
    // removals that must honour arrival order among equal priorities.
    task run_directed();
        // dequeue, peek and the spare code on an empty queue: -1, status empty
        send_request(ACT_PEEK,    32'sh1234_5678, 16'h0000);
        send_request(ACT_DEQUEUE, 32'sh0000_0000, 16'hFFFF);
        send_request(ACT_SPARE,   32'shFFFF_FFFF, 16'h5A5A);

        // value and priority extremes
        send_request(ACT_ENQUEUE, 32'sh7FFF_FFFF, 16'hFFFF);
        send_request(ACT_ENQUEUE, 32'sh8000_0000, 16'h0000);
        send_request(ACT_ENQUEUE, 32'shFFFF_FFFF, 16'h8000);
        // same priority as the current head: must queue behind it
        send_request(ACT_ENQUEUE, 32'sh0000_0000, 16'h0000);

        // fill the rest: a run of ties at one priority interleaved with
        // descending priorities that insert ahead of older entries
        for (int i = 0; i < CAPACITY - 4; i++) begin
            if (i % 2 == 0)
                send_request(ACT_ENQUEUE, 32'sh5555_0000 + i, 16'd100);
            else
                send_request(ACT_ENQUEUE, 32'shAAAA_0000 + i, 16'h7FFF - PRIO_W'(i));
        end

        // queue is full: this one is dropped with status full
        send_request(ACT_ENQUEUE, 32'sh0BAD_0BAD, 16'h0000);
        send_request(ACT_PEEK,    32'sh0000_0001, 16'h0001);
        send_request(ACT_SPARE,   32'sh0000_0002, 16'h0002);

        // both priority-zero entries leave in arrival order
        send_request(ACT_DEQUEUE, 32'sh0000_0003, 16'h0003);
        send_request(ACT_DEQUEUE, 32'sh0000_0004, 16'h0004);
        send_request(ACT_DEQUEUE, 32'sh0000_0005, 16'h0005);
    endtask

    // Random traffic in phases of fill, balance and drain so the queue
    // swings between full and empty many times. Priorities lean towards a
    // handful of small values to produce plenty of ties, with full-range
    // and extreme values mixed in.
    task run_random(input int count);
        int                  fill_bias;
        int                  phase_left;
        int unsigned         roll;
        logic [ACTION_W-1:0] act;
        logic [PRIO_W-1:0]   prio;
        fill_bias  = 50;
        phase_left = 0;
        for (int n = 0; n < count; n++) begin
            if (phase_left == 0) begin
                case ($urandom_range(0, 2))
                    0:       fill_bias = 80;
                    1:       fill_bias = 50;
                    default: fill_bias = 25;
                endcase
                phase_left = $urandom_range(20, 70);
            end
            phase_left--;

            roll = $urandom_range(0, 99);
            if (roll < fill_bias) begin
                act = ACT_ENQUEUE;
            end else begin
                roll = $urandom_range(0, 99);
                if (roll < 70)
                    act = ACT_DEQUEUE;
                else if (roll < 93)
                    act = ACT_PEEK;
                else
                    act = ACT_SPARE;
            end

            roll = $urandom_range(0, 9);
            if (roll < 5)
                prio = PRIO_W'($urandom_range(0, 7));
            else if (roll < 8)
                prio = PRIO_W'($urandom);
            else if (roll == 8)
                prio = '0;
            else
                prio = '1;

            // value is random on every beat, used or not
            send_request(act, $urandom, prio);
        end
    endtask

    initial begin
        // synchronous reset held low from the start, then released once
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        run_directed();
        run_random(RANDOM_REQUESTS);
        s_valid <= 1'b0;

        // every reply in, then a short quiet spell to catch strays
        do @(posedge aclk); while (pending_replies != 0);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("requests: %0d enqueue, %0d dequeue, %0d peek, %0d spare code",
                 enq_sent, deq_sent, peek_sent, spare_sent);
        $display("replies checked %0d, full drops %0d, empty replies %0d, peak fill %0d of %0d",
                 replies_checked, full_drops, empty_replies, peak_fill, CAPACITY);
        if (mismatches == 0 && pending_replies == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("%0d failing beats", mismatches);
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
